>>> hdl/ftwc_pkg.sv
// ----------------------------------------------------------------------------
// ftwc_pkg
// types, constants and codes shared by the five-tuple classifier modules
// ----------------------------------------------------------------------------
package ftwc_pkg;

  localparam int unsigned NODES  = 256;                   // entries per level
  localparam int unsigned LEVELS = 5;
  localparam int unsigned IW     = $clog2(NODES);         // entry index width
  localparam int unsigned CW     = $clog2(NODES + 1);     // fill count width
  localparam int unsigned LW     = 3;                     // level number width
  localparam int unsigned AW     = $clog2(LEVELS * NODES);
  localparam int unsigned EW     = IW + 34;               // entry width

  localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic        src_ip_any;
    logic [15:0] sport;
    logic        sport_any;
    logic [31:0] dst_ip;
    logic        dst_ip_any;
    logic [15:0] dport;
    logic        dport_any;
    logic        allow;
  } in_t;

  typedef struct packed {
    logic allowed;
    logic status;
  } out_t;

  typedef struct packed {
    logic [IW-1:0] parent;
    logic          wild;
    logic [31:0]   key;
    logic          allow;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DECIDE,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic clear_fill;
    logic rd;
    logic cmp;
    logic descend;
    logic wr_new;
    logic wr_leaf;
    logic res_load;
    logic res_allowed;
    logic res_status;
    logic push;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic scan_done;
    logic hit;
    logic hit_allow;
    logic last;
    logic room_ok;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/ftwc_ram.sv
// ----------------------------------------------------------------------------
// ftwc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module ftwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ftwc_datapath.sv
// ----------------------------------------------------------------------------
// ftwc_datapath
// level table ram, fill counts, scan compare and result registers
// ----------------------------------------------------------------------------
module ftwc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftwc_pkg::cmd_t      cmd_i,
  output ftwc_pkg::sts_t      sts_o,
  input  ftwc_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ftwc_pkg::out_t      out_data_o
);

  ftwc_pkg::in_t                item_q;
  logic [ftwc_pkg::LW-1:0]      lvl_q;
  logic [ftwc_pkg::CW-1:0]      idx_q;
  logic [ftwc_pkg::IW-1:0]      par_q;
  logic                         ex_hit_q, wc_hit_q;
  logic [ftwc_pkg::IW-1:0]      ex_idx_q, wc_idx_q;
  logic                         ex_allow_q, wc_allow_q;
  logic [ftwc_pkg::CW-1:0]      fill_q [ftwc_pkg::LEVELS];
  ftwc_pkg::out_t               res_q, out_q;
  logic                         out_valid_q;

  logic [31:0]                  lkey, skey;
  logic                         lwild, sw, is_ins, ex_m, wc_m, room_ok;
  logic [ftwc_pkg::CW-1:0]      fill_cur;
  logic [ftwc_pkg::IW-1:0]      acc_idx;
  logic [ftwc_pkg::AW-1:0]      addr;
  ftwc_pkg::entry_t             re, we_ent;
  logic                         we;

  // key and wildcard flag of the current level
  always_comb begin
    lkey  = '0;
    lwild = 1'b0;
    unique case (lvl_q)
      3'd0: lkey = {24'd0, item_q.protocol};
      3'd1: begin
        lkey  = item_q.src_ip;
        lwild = item_q.src_ip_any;
      end
      3'd2: begin
        lkey  = {16'd0, item_q.sport};
        lwild = item_q.sport_any;
      end
      3'd3: begin
        lkey  = item_q.dst_ip;
        lwild = item_q.dst_ip_any;
      end
      3'd4: begin
        lkey  = {16'd0, item_q.dport};
        lwild = item_q.dport_any;
      end
      default: begin
        lkey  = '0;
        lwild = 1'b0;
      end
    endcase
  end

  assign is_ins   = (ftwc_pkg::op_e'(item_q.operation) == ftwc_pkg::OP_INSERT);
  assign sw       = is_ins & lwild;
  assign skey     = sw ? 32'd0 : lkey;
  assign fill_cur = (lvl_q < ftwc_pkg::LW'(ftwc_pkg::LEVELS)) ? fill_q[lvl_q] : '0;

  assign ex_m = (re.parent == par_q) && (re.wild == sw) && (re.key == skey);
  assign wc_m = (re.parent == par_q) && re.wild && (re.key == 32'd0);

  always_comb begin
    room_ok = 1'b1;
    for (int l = 0; l < ftwc_pkg::LEVELS; l++) begin
      if ((ftwc_pkg::LW'(l) >= lvl_q) && (fill_q[l] == ftwc_pkg::CW'(ftwc_pkg::NODES))) begin
        room_ok = 1'b0;
      end
    end
  end

  // ram port
  always_comb begin
    priority if (cmd_i.wr_new) begin
      acc_idx = fill_cur[ftwc_pkg::IW-1:0];
    end else if (cmd_i.wr_leaf) begin
      acc_idx = ex_idx_q;
    end else begin
      acc_idx = idx_q[ftwc_pkg::IW-1:0];
    end
  end

  assign addr = ftwc_pkg::AW'(lvl_q) * ftwc_pkg::AW'(ftwc_pkg::NODES)
                + ftwc_pkg::AW'(acc_idx);
  assign we   = cmd_i.wr_new | cmd_i.wr_leaf;

  always_comb begin
    we_ent.parent = par_q;
    we_ent.wild   = sw;
    we_ent.key    = skey;
    we_ent.allow  = (lvl_q == ftwc_pkg::LVL_LAST) ? item_q.allow : 1'b0;
  end

  ftwc_ram #(
    .WIDTH (ftwc_pkg::EW),
    .DEPTH (ftwc_pkg::LEVELS * ftwc_pkg::NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (we_ent),
    .rdata_o (re)
  );

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= '0;
      idx_q       <= '0;
      par_q       <= '0;
      ex_hit_q    <= 1'b0;
      wc_hit_q    <= 1'b0;
      ex_idx_q    <= '0;
      wc_idx_q    <= '0;
      ex_allow_q  <= 1'b0;
      wc_allow_q  <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < ftwc_pkg::LEVELS; l++) begin
        fill_q[l] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        lvl_q    <= '0;
        idx_q    <= '0;
        par_q    <= '0;
        ex_hit_q <= 1'b0;
        wc_hit_q <= 1'b0;
      end
      if (cmd_i.cmp) begin
        if (ex_m && !ex_hit_q) begin
          ex_hit_q   <= 1'b1;
          ex_idx_q   <= idx_q[ftwc_pkg::IW-1:0];
          ex_allow_q <= re.allow;
        end
        if (wc_m && !wc_hit_q) begin
          wc_hit_q   <= 1'b1;
          wc_idx_q   <= idx_q[ftwc_pkg::IW-1:0];
          wc_allow_q <= re.allow;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.descend) begin
        par_q    <= ex_hit_q ? ex_idx_q : wc_idx_q;
        lvl_q    <= lvl_q + 1'b1;
        idx_q    <= '0;
        ex_hit_q <= 1'b0;
        wc_hit_q <= 1'b0;
      end
      if (cmd_i.wr_new) begin
        fill_q[lvl_q] <= fill_cur + 1'b1;
        par_q         <= fill_cur[ftwc_pkg::IW-1:0];
        lvl_q         <= lvl_q + 1'b1;
      end
      if (cmd_i.clear_fill) begin
        for (int l = 0; l < ftwc_pkg::LEVELS; l++) begin
          fill_q[l] <= '0;
        end
      end
      if (cmd_i.res_load) begin
        res_q.allowed <= cmd_i.res_allowed;
        res_q.status  <= cmd_i.res_status;
      end
      if (cmd_i.push) begin
        out_q       <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op        = ftwc_pkg::op_e'(item_q.operation);
    sts_o.scan_done = (idx_q == fill_cur);
    sts_o.hit       = ex_hit_q || (!is_ins && (lvl_q != '0) && wc_hit_q);
    sts_o.hit_allow = ex_hit_q ? ex_allow_q : wc_allow_q;
    sts_o.last      = (lvl_q == ftwc_pkg::LVL_LAST);
    sts_o.room_ok   = room_ok;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/ftwc_ctrl.sv
// ----------------------------------------------------------------------------
// ftwc_ctrl
// sequencer for clear, insert and lookup walks over the five levels
// ----------------------------------------------------------------------------
module ftwc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ftwc_pkg::sts_t sts_i,
  output ftwc_pkg::cmd_t cmd_o
);

  ftwc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftwc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ftwc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ftwc_pkg::ST_RD;
        end
      end
      ftwc_pkg::ST_RD: begin
        priority if (sts_i.op == ftwc_pkg::OP_CLEAR || sts_i.op == ftwc_pkg::OP_NONE) begin
          state_d = ftwc_pkg::ST_DONE;
        end else if (sts_i.scan_done) begin
          state_d = ftwc_pkg::ST_DECIDE;
        end else begin
          state_d = ftwc_pkg::ST_CMP;
        end
      end
      ftwc_pkg::ST_CMP: state_d = ftwc_pkg::ST_RD;
      ftwc_pkg::ST_DECIDE: begin
        priority if (sts_i.hit && !sts_i.last) begin
          state_d = ftwc_pkg::ST_RD;
        end else if (sts_i.op == ftwc_pkg::OP_INSERT && !sts_i.hit && sts_i.room_ok) begin
          state_d = ftwc_pkg::ST_WRITE;
        end else begin
          state_d = ftwc_pkg::ST_DONE;
        end
      end
      ftwc_pkg::ST_WRITE: begin
        if (sts_i.last) begin
          state_d = ftwc_pkg::ST_DONE;
        end
      end
      ftwc_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ftwc_pkg::ST_IDLE;
        end
      end
      default: state_d = ftwc_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ftwc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ftwc_pkg::ST_RD: begin
        priority if (sts_i.op == ftwc_pkg::OP_CLEAR) begin
          cmd_o.clear_fill = 1'b1;
          cmd_o.res_load   = 1'b1;
        end else if (sts_i.op == ftwc_pkg::OP_NONE) begin
          cmd_o.res_load = 1'b1;
        end else if (!sts_i.scan_done) begin
          cmd_o.rd = 1'b1;
        end else begin
          cmd_o.rd = 1'b0;
        end
      end
      ftwc_pkg::ST_CMP: cmd_o.cmp = 1'b1;
      ftwc_pkg::ST_DECIDE: begin
        priority if (sts_i.hit && !sts_i.last) begin
          cmd_o.descend = 1'b1;
        end else if (sts_i.op == ftwc_pkg::OP_LOOKUP) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.res_allowed = sts_i.hit & sts_i.hit_allow;
        end else if (sts_i.hit) begin
          // rule already present: overwrite the leaf
          cmd_o.wr_leaf  = 1'b1;
          cmd_o.res_load = 1'b1;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = !sts_i.room_ok;
        end
      end
      ftwc_pkg::ST_WRITE: cmd_o.wr_new = 1'b1;
      ftwc_pkg::ST_DONE:  cmd_o.push   = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> hdl/five_tuple_wildcard_classifier.sv
// ----------------------------------------------------------------------------
// five_tuple_wildcard_classifier
// firewall rule store as a five-level trie: clear, insert rule, look up packet
// ----------------------------------------------------------------------------
// one item is worked at a time. the five level tables share one single-port
// ram and each level is searched linearly: every used entry is read, then
// compared, and each walked level ends in a decide step that descends, writes
// or finishes; an insert then writes one new entry for every level that it
// creates, or none if a level it needs is full. a clear or an unknown
// operation skips the search and the walk. freed entries need no
// clearing pass: the per-level fill counts mark which entries are live, and a
// clear simply zeroes them. a finished result waits in the output register
// while the next item is accepted
// ----------------------------------------------------------------------------
module five_tuple_wildcard_classifier (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ftwc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ftwc_pkg::out_t out_data_o
);

  ftwc_pkg::cmd_t cmd;
  ftwc_pkg::sts_t sts;

  // walk sequencer
  ftwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables, counts and result transfer
  ftwc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/rule_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rule_checker
// watches both channels, keeps its own copy of the rule trie and compares
// every verdict and status against the predicted one
// ----------------------------------------------------------------------------
module rule_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  ftwc_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  ftwc_pkg::out_t out_data_i,
  output int             errors_o,
  output int             pending_o
);

  typedef struct {
    bit        valid;
    bit [7:0]  parent;
    bit        wild;
    bit [31:0] key;
    bit        allow;
  } node_t;

  node_t           trie [ftwc_pkg::LEVELS][ftwc_pkg::NODES];
  int unsigned     fill [ftwc_pkg::LEVELS] = '{default: 0};
  ftwc_pkg::out_t  verdicts [$];
  int              errors = 0;

  function automatic int find_node(int lv, int par, bit w, bit [31:0] k);
    for (int i = 0; i < fill[lv]; i++)
      if (trie[lv][i].valid && trie[lv][i].parent == par && trie[lv][i].wild == w &&
          trie[lv][i].key == k)
        return i;
    return -1;
  endfunction

  function automatic ftwc_pkg::out_t classify(ftwc_pkg::in_t it);
    bit [31:0]      keys [ftwc_pkg::LEVELS];
    bit             wild [ftwc_pkg::LEVELS];
    ftwc_pkg::out_t r;
    int             par;
    int             first;
    int             f;
    bit             full;
    r = '0;
    keys = '{32'(it.protocol), it.src_ip, 32'(it.sport), it.dst_ip, 32'(it.dport)};
    wild = '{1'b0, it.src_ip_any, it.sport_any, it.dst_ip_any, it.dport_any};
    case (ftwc_pkg::op_e'(it.operation))
      ftwc_pkg::OP_CLEAR: begin
        foreach (fill[l]) begin
          fill[l] = 0;
          foreach (trie[l][i]) trie[l][i].valid = 0;
        end
      end
      ftwc_pkg::OP_INSERT: begin
        par = 0;
        first = ftwc_pkg::LEVELS;
        full = 0;
        for (int l = 0; l < ftwc_pkg::LEVELS; l++) begin
          f = find_node(l, par, wild[l], wild[l] ? 32'd0 : keys[l]);
          if (f < 0) begin
            first = l;
            break;
          end
          par = f;
        end
        for (int l = first; l < ftwc_pkg::LEVELS; l++)
          if (fill[l] >= ftwc_pkg::NODES) full = 1;
        if (full) r.status = 1'b1;
        else begin
          for (int l = first; l < ftwc_pkg::LEVELS; l++) begin
            trie[l][fill[l]] = '{1'b1, 8'(par), wild[l], wild[l] ? 32'd0 : keys[l], 1'b0};
            par = fill[l];
            fill[l]++;
          end
          trie[ftwc_pkg::LEVELS-1][par].allow = it.allow;
        end
      end
      ftwc_pkg::OP_LOOKUP: begin
        // exact child first, wildcard otherwise, never backtrack
        f = find_node(0, 0, 1'b0, keys[0]);
        for (int l = 1; l < ftwc_pkg::LEVELS && f >= 0; l++) begin
          par = f;
          f = find_node(l, par, 1'b0, keys[l]);
          if (f < 0) f = find_node(l, par, 1'b1, 32'd0);
        end
        if (f >= 0 && trie[ftwc_pkg::LEVELS-1][f].allow) r.allowed = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = verdicts.size();
  assign errors_o  = errors;

  always @(posedge clk_i) begin
    ftwc_pkg::out_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %b", $time, out_data_i);
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (want.allowed !== out_data_i.allowed) begin
            $display("%0t: allowed expected %b actual %b", $time, want.allowed,
                     out_data_i.allowed);
            errors++;
          end
          if (want.status !== out_data_i.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status,
                     out_data_i.status);
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) verdicts.push_back(classify(in_data_i));
    end
  end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives clears, rule inserts and packet lookups into the classifier under
// varying idle and stall patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;

  logic           clk = 0;
  logic           rst_n = 0;
  logic           in_valid = 0;
  logic           in_ready;
  ftwc_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 0;
  ftwc_pkg::out_t out_data;
  int   errors;
  int   pending;
  int   idle_pct = 0;    // sender gap chance, percent
  int   stall_pct = 0;   // receiver stall chance, percent
  int   quiet = 0;       // cycles with no transfer
  // the limit lies well above the slowest item; stalls and gaps add far less
  localparam int QUIET_LIMIT = 40000;

  // a small pool of rule values so lookups hit inserted rules
  bit [31:0] ip_pool [4] = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0001};
  bit [15:0] port_pool [4] = '{16'h0, 16'hFFFF, 16'd80, 16'd443};
  bit [7:0]  proto_pool [4] = '{8'd6, 8'd17, 8'd0, 8'd255};

  always #1 clk = ~clk;

  five_tuple_wildcard_classifier dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  rule_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending)
  );

  // receiver stalls at random
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("five_tuple_wildcard_classifier: mismatch");
      $finish;
    end
  end

  // one transfer: optional gap first, then hold valid until accepted
  task automatic send(ftwc_pkg::in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic ftwc_pkg::in_t make_rule_item(bit [1:0] op, bit pooled);
    ftwc_pkg::in_t it;
    it = '0;
    it.operation = op;
    it.protocol  = pooled ? proto_pool[$urandom_range(3)] : 8'($urandom);
    it.src_ip    = pooled ? ip_pool[$urandom_range(3)] : $urandom;
    it.sport     = pooled ? port_pool[$urandom_range(3)] : 16'($urandom);
    it.dst_ip    = pooled ? ip_pool[$urandom_range(3)] : $urandom;
    it.dport     = pooled ? port_pool[$urandom_range(3)] : 16'($urandom);
    it.src_ip_any = $urandom_range(3) == 0;
    it.sport_any  = $urandom_range(3) == 0;
    it.dst_ip_any = $urandom_range(3) == 0;
    it.dport_any  = $urandom_range(3) == 0;
    it.allow      = $urandom_range(1);
    return it;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    ftwc_pkg::in_t it;
    int            r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: specific rule, wildcard fallback, no backtracking, overwrite
    it = '0;
    it.operation = ftwc_pkg::OP_LOOKUP;
    send(it);                                  // empty store denies
    it = '{ftwc_pkg::OP_INSERT, 8'd6, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0,
           32'hFFFF_FFFF, 1'b0, 16'hFFFF, 1'b0, 1'b1};
    send(it);
    it.operation = ftwc_pkg::OP_LOOKUP; send(it);        // exact hit allows
    it.operation = ftwc_pkg::OP_INSERT; it.allow = 1'b0; send(it);   // overwrite to deny
    it.operation = ftwc_pkg::OP_LOOKUP; send(it);
    it = '{ftwc_pkg::OP_INSERT, 8'd17, 32'h0, 1'b1, 16'h0, 1'b1, 32'h0, 1'b1, 16'h0, 1'b1,
           1'b1};
    send(it);                                  // all-wildcard udp rule
    it = '{ftwc_pkg::OP_LOOKUP, 8'd17, 32'h1234_5678, 1'b0, 16'd53, 1'b0,
           32'h8765_4321, 1'b0, 16'd53, 1'b0, 1'b0};
    send(it);
    // exact src address child exists but dead-ends: no backtrack to wildcard
    it = '{ftwc_pkg::OP_INSERT, 8'd17, 32'h1234_5678, 1'b0, 16'd1, 1'b0, 32'h0, 1'b1,
           16'h0, 1'b1, 1'b1};
    send(it);
    it = '{ftwc_pkg::OP_LOOKUP, 8'd17, 32'h1234_5678, 1'b0, 16'd53, 1'b0,
           32'h8765_4321, 1'b0, 16'd53, 1'b0, 1'b0};
    send(it);
    it.protocol = 8'd18; send(it);             // protocol must match exactly
    it = '1; it.operation = ftwc_pkg::OP_NONE; send(it);  // unknown operation
    it.operation = ftwc_pkg::OP_LOOKUP; send(it);
    it = '1; it.operation = ftwc_pkg::OP_CLEAR; send(it);
    it = '{ftwc_pkg::OP_LOOKUP, 8'd17, 32'h1, 1'b0, 16'd2, 1'b0, 32'h3, 1'b0, 16'd4, 1'b0,
           1'b1};
    send(it);
    drain();                                   // hold off until all results back

    // fill the leaf level to overflow, then check rejection and a clear
    for (int i = 0; i < ftwc_pkg::NODES + 2; i++) begin
      it = '{ftwc_pkg::OP_INSERT, 8'd6, 32'h0A00_0001, 1'b0, 16'd80, 1'b0, 32'h0, 1'b0,
             16'(i), 1'b0, i[0]};
      send(it);
    end
    it.operation = ftwc_pkg::OP_LOOKUP; it.dport = 16'd7; send(it);
    it.dport = 16'd300; send(it);
    it = '0; it.operation = ftwc_pkg::OP_CLEAR; send(it);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 87 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 87 : (ph == 3) ? 23 : 0;
      for (int n = 0; n < 30; n++) begin
        r = $urandom_range(99);
        if (r < 2) it = make_rule_item(ftwc_pkg::OP_CLEAR, 1'b0);
        else if (r < 4) it = make_rule_item(ftwc_pkg::OP_NONE, 1'b0);
        else if (r < 45) it = make_rule_item(ftwc_pkg::OP_INSERT, r < 40);
        else it = make_rule_item(ftwc_pkg::OP_LOOKUP, r < 90);
        send(it);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("five_tuple_wildcard_classifier: match");
    else $display("five_tuple_wildcard_classifier: mismatch");
    $finish;
  end
endmodule
